[rtl/stuffed_frame_receiver_crc16_macros.svh]
// assertion macros shared by the checker
`ifndef STUFFED_FRAME_RECEIVER_CRC16_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sfr_pkg.sv]
package sfr_pkg;

	localparam logic [7:0]  SYNC_A      = 8'h77;
	localparam logic [7:0]  SYNC_B      = 8'h21;
	localparam logic [7:0]  STUFF_FILL  = 8'h00;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [1:0]  LBI_RESET   = 2'd3;
	localparam logic [1:0]  LBI_MIN     = 2'd2;
	localparam logic [6:0]  MFL_RESET   = 7'd127;
	localparam logic [6:0]  COUNT_LIMIT = 7'd127;

	// register index, taken from paddr[2]
	localparam logic REG_LBI = 1'b0;
	localparam logic REG_MFL = 1'b1;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_GOOD  = 2'd1,
		KIND_BAD   = 2'd2,
		KIND_ABORT = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] lbi;
		logic [6:0] mfl;
	} cfg_t;

	typedef struct packed {
		logic        in_frame;
		logic [6:0]  count;
		logic [7:0]  flen;
		logic [15:0] crc;
	} frm_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	// results caused by one input byte
	typedef struct packed {
		logic [1:0]      cnt;
		res_t [2:0]      res;
	} run_t;

	typedef struct packed {
		frm_t  st;
		logic  emit;
		logic  fin;
		kind_t fin_kind;
	} stor_t;

	localparam frm_t FRM_RESET = '{in_frame: 1'b0, count: 7'd0, flen: 8'd0, crc: CRC_INIT};
	localparam frm_t FRM_OPEN  = '{in_frame: 1'b1, count: 7'd0, flen: 8'd0, crc: CRC_INIT};

	// crc-16/ccitt-false, msb first, one byte
	function automatic logic [15:0] sfr_crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// store one byte into the open frame and check for the frame end
	function automatic stor_t sfr_store(frm_t s, logic [7:0] b, cfg_t cfg);
		stor_t r;
		r.st       = s;
		r.emit     = 1'b0;
		r.fin      = 1'b0;
		r.fin_kind = KIND_BYTE;
		if (s.in_frame) begin
			r.emit = 1'b1;
			if (s.count >= 7'd2) begin
				r.st.crc = sfr_crc_byte(s.crc, b);
			end
			r.st.count = s.count + 7'd1;
			if (s.count == {5'd0, cfg.lbi}) begin
				r.st.flen = b;
				if (b < ({6'd0, cfg.lbi} + 8'd2) || b > {1'b0, cfg.mfl}) begin
					r.st.in_frame = 1'b0;
					r.fin         = 1'b1;
					r.fin_kind    = KIND_ABORT;
				end
			end else if ({1'b0, r.st.count} > ({6'd0, cfg.lbi} + 8'd1)
					&& {1'b0, r.st.count} == s.flen) begin
				r.st.in_frame = 1'b0;
				r.fin         = 1'b1;
				r.fin_kind    = (r.st.crc == 16'd0) ? KIND_GOOD : KIND_BAD;
			end else if (r.st.count >= cfg.mfl || r.st.count == COUNT_LIMIT) begin
				r.st.in_frame = 1'b0;
				r.fin         = 1'b1;
				r.fin_kind    = KIND_ABORT;
			end
		end
		return r;
	endfunction

	function automatic run_t sfr_run_add(run_t r, logic [7:0] data, kind_t kind);
		run_t o;
		o                  = r;
		o.res[r.cnt].data  = data;
		o.res[r.cnt].kind  = kind;
		o.cnt              = r.cnt + 2'd1;
		return o;
	endfunction

	function automatic run_t sfr_run_store(run_t r, stor_t s, logic [7:0] b);
		run_t o;
		o = r;
		if (s.emit) begin
			o = sfr_run_add(o, b, KIND_BYTE);
		end
		if (s.fin) begin
			o = sfr_run_add(o, 8'h00, s.fin_kind);
		end
		return o;
	endfunction

endpackage

[rtl/sfr_cfg.sv]
module sfr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output sfr_pkg::cfg_t     cfg
);
	import sfr_pkg::*;

	logic [1:0] lbi_q;
	logic [6:0] mfl_q;
	logic       wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbi_q <= LBI_RESET;
			mfl_q <= MFL_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_LBI) begin
				// positions below two are not legal and are ignored
				if (pwdata[1:0] >= LBI_MIN) begin
					lbi_q <= pwdata[1:0];
				end
			end else begin
				mfl_q <= pwdata[6:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_MFL) begin
			prdata = {25'd0, mfl_q};
		end else begin
			prdata = {30'd0, lbi_q};
		end
	end

	assign cfg.lbi = lbi_q;
	assign cfg.mfl = mfl_q;

endmodule

[rtl/sfr_deframe.sv]
module sfr_deframe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        rx_byte_s1,
	input  sfr_pkg::cfg_t     cfg,
	output sfr_pkg::run_t     run
);
	import sfr_pkg::*;

	logic  esc_q;
	frm_t  frm_q;
	logic  esc_d;
	frm_t  frm_d;
	stor_t sa;
	stor_t sb;

	always_comb begin
		run   = '0;
		esc_d = esc_q;
		frm_d = frm_q;
		sa    = '0;
		sb    = '0;
		if (!esc_q) begin
			if (rx_byte_s1 == SYNC_A) begin
				esc_d = 1'b1;
			end else begin
				sa    = sfr_store(frm_d, rx_byte_s1, cfg);
				frm_d = sa.st;
				run   = sfr_run_store(run, sa, rx_byte_s1);
			end
		end else begin
			esc_d = 1'b0;
			if (rx_byte_s1 == SYNC_B) begin
				// sync inside a frame drops the open one first
				if (frm_d.in_frame) begin
					run = sfr_run_add(run, 8'h00, KIND_ABORT);
				end
				sa    = sfr_store(FRM_OPEN, SYNC_A, cfg);
				sb    = sfr_store(sa.st, SYNC_B, cfg);
				frm_d = sb.st;
				run   = sfr_run_store(run, sa, SYNC_A);
				run   = sfr_run_store(run, sb, SYNC_B);
			end else if (rx_byte_s1 == STUFF_FILL && frm_d.in_frame) begin
				sa    = sfr_store(frm_d, SYNC_A, cfg);
				frm_d = sa.st;
				run   = sfr_run_store(run, sa, SYNC_A);
			end else begin
				// lone escape byte is plain data
				sa    = sfr_store(frm_d, SYNC_A, cfg);
				frm_d = sa.st;
				run   = sfr_run_store(run, sa, SYNC_A);
				if (rx_byte_s1 == SYNC_A) begin
					esc_d = 1'b1;
				end else begin
					sb    = sfr_store(frm_d, rx_byte_s1, cfg);
					frm_d = sb.st;
					run   = sfr_run_store(run, sb, rx_byte_s1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			frm_q <= FRM_RESET;
		end else if (step_en) begin
			esc_q <= esc_d;
			frm_q <= frm_d;
		end
	end

endmodule

[rtl/sfr_run_buf.sv]
module sfr_run_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sfr_pkg::run_t     run,
	output logic              load_ok,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        out_byte,
	output logic [1:0]        result_kind,
	output logic              last_of_run
);
	import sfr_pkg::*;

	run_t       run_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       pop;
	logic       is_last;

	assign is_last = (idx_q == (run_q.cnt - 2'd1));
	assign pop     = busy_q && res_ready;
	assign load_ok = !busy_q || (pop && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load && load_ok) begin
			busy_q <= (run.cnt != 2'd0);
			idx_q  <= 2'd0;
		end else if (pop) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			run_q <= run;
		end
	end

	assign res_valid   = busy_q;
	assign out_byte    = run_q.res[idx_q].data;
	assign result_kind = run_q.res[idx_q].kind;
	assign last_of_run = is_last;

endmodule

[rtl/stuffed_frame_receiver_crc16.sv]
// Byte-stuffed frame receiver with CRC-16/CCITT-FALSE check. One raw line byte
// enters per rx transaction; the pair 0x77 0x21 opens a frame, 0x77 0x00 inside
// a frame stands for a data byte 0x77, and bytes outside a frame are dropped.
// Every stored frame byte comes out as a result of kind 0; when the count
// reaches the length byte (at position length_byte_index) a kind 1 (crc good)
// or kind 2 (crc bad) result closes the frame, and kind 3 reports a frame
// abandoned by a new sync, a bad length byte or an overrun. last_of_run marks
// the final result of each input byte; a byte may cause none and at most three.
// Timing: a byte is held in the input register while its whole run of results
// is worked out combinationally; the run is loaded into the run buffer once the
// buffer can take it, and the first result is offered from that register. The
// single result port drains the run buffer one result per cycle while res_ready
// is high, which sets the rate: a byte with several results holds the next
// byte in the input register until its run is taken, so the block takes one
// byte per cycle only while res_ready stays high and no byte has several results.
// Registers (32-bit apb, pready always high): 0x0 length_byte_index (2..3,
// writes of 0 or 1 are dropped, reset 3), 0x4 max_frame_length (reset 127).
// Change registers only while no frame traffic is in flight.
module stuffed_frame_receiver_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	// receive channel
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  out_byte,
	output logic [1:0]  result_kind,
	output logic        last_of_run,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfr_pkg::*;

	cfg_t       cfg;
	run_t       run;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       load_ok;
	logic       take;

	// input byte moves on once the run buffer can take its results
	assign take     = valid_s1 && load_ok;
	assign rx_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// unstuffing, framing and crc state, one byte per step
	sfr_deframe u_deframe (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (take),
		.rx_byte_s1 (rx_byte_s1),
		.cfg        (cfg),
		.run        (run)
	);

	// holds up to three results of one byte and hands them out in order
	sfr_run_buf u_run_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take),
		.run         (run),
		.load_ok     (load_ok),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_byte    (out_byte),
		.result_kind (result_kind),
		.last_of_run (last_of_run)
	);

endmodule

[rtl/sfr_checker.sv]
`include "stuffed_frame_receiver_crc16_macros.svh"

module sfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [7:0]  out_byte,
	input logic [1:0]  result_kind,
	input logic        last_of_run,
	input logic        pready
);
	import sfr_pkg::*;

	logic        is_status;
	logic        is_crc_end;
	logic        abort_mid;
	logic        sync_head;
	logic        res_stall;
	logic [10:0] res_word;

	assign is_status  = res_valid && result_kind != KIND_BYTE;
	assign is_crc_end = res_valid && (result_kind == KIND_GOOD || result_kind == KIND_BAD);
	assign abort_mid  = res_valid && res_ready && result_kind == KIND_ABORT && !last_of_run;
	assign sync_head  = res_valid && result_kind == KIND_BYTE && out_byte == SYNC_A;
	assign res_stall  = res_valid && !res_ready;
	assign res_word   = {out_byte, result_kind, last_of_run};

	`SFR_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

	`SFR_ASSERT_NOW(a_status_zero_byte, is_status, out_byte == 8'h00, "status with nonzero byte")

	`SFR_ASSERT_NOW(a_crc_end_last, is_crc_end, last_of_run, "frame end not last of its byte")

	`SFR_ASSERT_NEXT(a_resync_follows, abort_mid, sync_head, "abandon not followed by sync")

	`SFR_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_word), "stalled result changed")

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (.*);

[tb/stuffed_frame_receiver_crc16_tb.sv]
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16_tb;
	import sfr_pkg::*;

	// run limit, far above the slowest legal run
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 470;
	localparam int PHASE_ITEMS = 60;

	// one result transaction as the deframer should emit it
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} frame_result_t;

	// deframer state machine mirrored in software, with the queue of results due
	class deframer_model;
		logic [1:0]    len_idx;
		logic [6:0]    max_len;
		bit            esc_pending;
		bit            frame_open;
		logic [6:0]    byte_count;
		logic [7:0]    length_byte;
		logic [15:0]   crc;
		frame_result_t run[$];
		frame_result_t results_due[$];
		int            errors;

		function new();
			len_idx     = LBI_RESET;
			max_len     = MFL_RESET;
			esc_pending = 1'b0;
			frame_open  = 1'b0;
			byte_count  = '0;
			length_byte = '0;
			crc         = CRC_INIT;
			errors      = 0;
		endfunction

		function void set_reg(logic sel, logic [31:0] v);
			if (sel == REG_LBI) begin
				// index values below the minimum are dropped
				if (v[1:0] >= LBI_MIN) begin
					len_idx = v[1:0];
				end
			end else begin
				max_len = v[6:0];
			end
		endfunction

		// bit-serial crc-16/ccitt-false, msb first
		static function logic [15:0] crc16(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c  = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void emit(logic [7:0] d, kind_t k);
			frame_result_t r;
			r.data = d;
			r.kind = k;
			r.last = 1'b0;
			run.push_back(r);
		endfunction

		// one byte into the open frame, then the end-of-frame tests
		function void store(logic [7:0] b);
			logic [6:0] pos;
			if (!frame_open) begin
				return;
			end
			pos = byte_count;
			if (pos >= 7'd2) begin
				crc = crc16(crc, b);
			end
			byte_count = pos + 7'd1;
			emit(b, KIND_BYTE);
			if (pos == 7'(len_idx)) begin
				length_byte = b;
				if (int'(b) < int'(len_idx) + 2 || int'(b) > int'(max_len)) begin
					frame_open = 1'b0;
					emit(8'h00, KIND_ABORT);
				end
			end else if (int'(byte_count) > int'(len_idx) + 1
					&& int'(byte_count) == int'(length_byte)) begin
				frame_open = 1'b0;
				emit(8'h00, (crc == 16'h0000) ? KIND_GOOD : KIND_BAD);
			end else if (byte_count >= max_len || byte_count >= COUNT_LIMIT) begin
				frame_open = 1'b0;
				emit(8'h00, KIND_ABORT);
			end
		endfunction

		// an rx transaction was accepted: predict its run of results
		function void take_byte(logic [7:0] b);
			run.delete();
			if (!esc_pending) begin
				if (b == SYNC_A) begin
					esc_pending = 1'b1;
				end else begin
					store(b);
				end
			end else begin
				esc_pending = 1'b0;
				if (b == SYNC_B) begin
					if (frame_open) begin
						emit(8'h00, KIND_ABORT);
					end
					frame_open  = 1'b1;
					byte_count  = '0;
					length_byte = '0;
					crc         = CRC_INIT;
					store(SYNC_A);
					store(SYNC_B);
				end else if (b == STUFF_FILL && frame_open) begin
					store(SYNC_A);
				end else begin
					// lone escape byte is plain data
					store(SYNC_A);
					if (b == SYNC_A) begin
						esc_pending = 1'b1;
					end else begin
						store(b);
					end
				end
			end
			if (run.size() > 0) begin
				run[run.size() - 1].last = 1'b1;
			end
			foreach (run[i]) begin
				results_due.push_back(run[i]);
			end
		endfunction

		// a result transaction was accepted: compare with the oldest one due
		function void check_result(logic [7:0] d, logic [1:0] k, logic l);
			frame_result_t want;
			if (results_due.size() == 0) begin
				$error("unexpected result: out_byte %0h result_kind %0d", d, k);
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (d !== want.data) begin
				$error("out_byte: expected %0h, got %0h", want.data, d);
				errors++;
			end
			if (k !== want.kind) begin
				$error("result_kind: expected %0d, got %0d", want.kind, k);
				errors++;
			end
			if (l !== want.last) begin
				$error("last_of_run: expected %0b, got %0b", want.last, l);
				errors++;
			end
		endfunction
	endclass

	// clock and all block inputs, known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  result_kind;
	logic        last_of_run;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	deframer_model model = new();
	int            items_sent = 0;
	int            cycle_count = 0;
	bit            no_gaps = 1'b0;

	stuffed_frame_receiver_crc16 uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_byte    (out_byte),
		.result_kind (result_kind),
		.last_of_run (last_of_run),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// idle cycles before a transaction, none during back-to-back stretches
	function automatic int draw_gap();
		return no_gaps ? 0 : int'($urandom_range(0, 11));
	endfunction

	// frame content biased toward the escape, sync and fill codes
	function automatic logic [7:0] content_byte();
		case ($urandom_range(0, 9))
			0: return SYNC_A;
			1: return SYNC_B;
			2: return STUFF_FILL;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// legal frame length for the current settings, mostly short
	function automatic int pick_len();
		int lo;
		int hi;
		lo = int'(model.len_idx) + 2;
		hi = int'(model.max_len);
		if (lo > hi) begin
			return lo;
		end
		if ($urandom_range(0, 14) == 0) begin
			return $urandom_range(lo, hi);
		end
		return $urandom_range(lo, (hi < lo + 10) ? hi : lo + 10);
	endfunction

	// one rx transaction; called at a falling edge, returns at a falling edge
	// with valid still high so that back-to-back bytes keep it up
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			rx_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!rx_ready);
		model.take_byte(b);
		@(negedge clk);
	endtask

	// hold the sender until every result due has come out, plus the pipeline
	task automatic wait_drain();
		rx_valid = 1'b0;
		while (model.results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle; junk in the unused upper bits
	task automatic reg_write(logic sel, logic [6:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {sel, 2'b00};
		if (sel == REG_LBI) begin
			pwdata = ($urandom() & 32'hFFFF_FFFC) | 32'(v[1:0]);
		end else begin
			pwdata = ($urandom() & 32'hFFFF_FF80) | 32'(v);
		end
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		model.set_reg(sel, pwdata);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// build a frame with a big-endian crc trailer, stuff it, and send the
	// first stop_at line bytes; a bad length byte makes a short frame
	task automatic send_frame(int flen_val, bit corrupt, int stop_at);
		logic [7:0]  fb[$];
		logic [7:0]  raw[$];
		logic [15:0] c;
		int          n;
		int          li;
		int          k;
		bit          bad;
		li  = int'(model.len_idx);
		bad = flen_val < li + 2 || flen_val > int'(model.max_len);
		n   = bad ? li + 1 + int'($urandom_range(0, 3)) : flen_val;
		fb.push_back(SYNC_A);
		fb.push_back(SYNC_B);
		for (int i = 2; i < n; i++) begin
			fb.push_back(content_byte());
		end
		fb[li] = flen_val[7:0];
		if (!bad && n - 2 > li) begin
			c = CRC_INIT;
			for (int i = 2; i < n - 2; i++) begin
				c = deframer_model::crc16(c, fb[i]);
			end
			fb[n - 2] = c[15:8];
			fb[n - 1] = c[7:0];
			// flip one bit after the length byte for a crc failure
			if (corrupt) begin
				k = $urandom_range(li + 1, n - 1);
				fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		raw.push_back(SYNC_A);
		raw.push_back(SYNC_B);
		for (int i = 2; i < fb.size(); i++) begin
			raw.push_back(fb[i]);
			if (fb[i] == SYNC_A) begin
				raw.push_back(STUFF_FILL);
			end
		end
		n = (stop_at < raw.size()) ? stop_at : raw.size();
		for (int i = 0; i < n; i++) begin
			send_byte(raw[i]);
		end
		items_sent += n;
	endtask

	// line bytes between frames, mostly dropped by the block
	task automatic send_noise(int n);
		for (int i = 0; i < n; i++) begin
			send_byte(content_byte());
		end
	endtask

	// result side: random stalls, one result transaction per handshake
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				res_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ready = 1'b1;
			do @(posedge clk); while (!res_valid);
			model.check_result(out_byte, result_kind, last_of_run);
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		logic [7:0] directed[$];
		int         phase_end;
		int         li;
		int         ml;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at reset settings (index 3, max length 127)
		directed = {
			// escape + fill outside a frame is dropped, as are loose bytes
			SYNC_A, STUFF_FILL, 8'h00, 8'hFF, SYNC_B,
			// length byte below the minimum
			SYNC_A, SYNC_B, 8'hFF, 8'd4,
			// open frame: stuffed escape, lone escape before data,
			// double escape before data
			SYNC_A, SYNC_B, 8'h00, 8'd12, SYNC_A, STUFF_FILL,
			SYNC_A, 8'h55, SYNC_A, SYNC_A, 8'h80,
			// sync inside a frame abandons it and opens the next one
			SYNC_A, SYNC_B, 8'h01,
			// length byte above the maximum
			8'd200
		};
		foreach (directed[i]) begin
			send_byte(directed[i]);
		end
		items_sent += directed.size();
		// a clean frame with a good trailer
		send_frame(9, 1'b0, 1000);
		wait_drain();

		// random part, one register setting per phase
		for (int p = 0; items_sent < ITEM_TARGET; p++) begin
			wait_drain();
			no_gaps = (p % 4 == 3);
			case (p)
				0: begin
					// index write below the minimum is dropped
					reg_write(REG_LBI, 7'd1);
					reg_write(REG_MFL, 7'd127);
				end
				1: begin
					reg_write(REG_LBI, 7'd2);
					reg_write(REG_MFL, 7'd4);
				end
				2: begin
					reg_write(REG_LBI, 7'd2);
					reg_write(REG_MFL, 7'd127);
					// max length lowered under an open frame: overrun abandon
					send_frame(60, 1'b0, 20);
					wait_drain();
					reg_write(REG_MFL, 7'd10);
					send_byte(8'h11);
					send_byte(8'h12);
					items_sent += 2;
					wait_drain();
					reg_write(REG_MFL, 7'd127);
				end
				3: begin
					reg_write(REG_LBI, 7'd3);
					reg_write(REG_MFL, 7'd5);
				end
				4: begin
					reg_write(REG_LBI, 7'd0);
					reg_write(REG_MFL, 7'($urandom_range(4, 127)));
				end
				default: begin
					reg_write(REG_LBI, 7'($urandom_range(0, 3)));
					case ($urandom_range(0, 3))
						0: reg_write(REG_MFL, 7'd127);
						1: reg_write(REG_MFL, 7'($urandom_range(4, 12)));
						default: reg_write(REG_MFL, 7'($urandom_range(13, 127)));
					endcase
				end
			endcase

			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				li = int'(model.len_idx);
				ml = int'(model.max_len);
				case ($urandom_range(0, 9))
					6: send_frame(pick_len(), 1'b0, $urandom_range(2, 8));
					7: begin
						if ($urandom_range(0, 1) == 0) begin
							send_frame($urandom_range(0, li + 1), 1'b0, 1000);
						end else begin
							send_frame($urandom_range(ml + 1, 255), 1'b0, 1000);
						end
					end
					8: send_noise($urandom_range(1, 6));
					9: send_frame(pick_len(), 1'b1, 1000);
					default: send_frame(pick_len(), $urandom_range(0, 3) == 0, 1000);
				endcase
				// now and then the sender holds until everything has drained
				if ($urandom_range(0, 19) == 0) begin
					wait_drain();
				end
			end
		end

		// drain, then let the pipeline settle
		rx_valid = 1'b0;
		while (model.results_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (model.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
